[hw/rtl/mipc_pkg.sv]
package mipc_pkg;

    // Configuration register indexes, in the order of the register list.
    localparam int unsigned CFG_INDEX_BITS = 2;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_BOX_LEN_X   = 2'd0,
        CFG_BOX_LEN_Y   = 2'd1,
        CFG_BOX_LEN_Z   = 2'd2,
        CFG_CUTOFF      = 2'd3
    } cfg_reg_t;

    // Periodic image offset, two-bit two's complement.
    typedef logic [1:0] img_t;

    localparam img_t IMG_NEG  = 2'b11;
    localparam img_t IMG_ZERO = 2'b00;
    localparam img_t IMG_POS  = 2'b01;

endpackage

[hw/rtl/mipc_skid.sv]
module mipc_skid #(
    parameter int W = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [W-1:0] s_data,
    input  logic         en,
    output logic         out_valid,
    output logic [W-1:0] out_data
);

    logic         full_reg;
    logic         full_next;
    logic [W-1:0] buf_reg;

    // The buffer holds a request that arrived while the pipeline was stalled.
    assign s_ready   = !full_reg;
    assign out_valid = full_reg || s_valid;
    assign out_data  = full_reg ? buf_reg : s_data;

    always_comb begin
        full_next = full_reg;
        if (en) begin
            full_next = 1'b0;
        end else if (s_valid && !full_reg) begin
            full_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg <= 1'b0;
        end else begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!en && s_valid && !full_reg) begin
            buf_reg <= s_data;
        end
    end

endmodule

[hw/rtl/mipc_axis.sv]
module mipc_axis #(
    parameter int COORD_BITS = 24
) (
    input  logic                         aclk,
    input  logic                         en,
    input  logic [COORD_BITS-1:0]        first,
    input  logic [COORD_BITS-1:0]        second,
    input  logic [COORD_BITS-1:0]        box_len,
    output logic signed [COORD_BITS:0]   disp,
    output mipc_pkg::img_t               img,
    output logic [2*COORD_BITS-1:0]      sq
);

    localparam int DISP_W = COORD_BITS + 1;
    localparam int SQ_W   = 2 * COORD_BITS;

    // Stage 1: raw difference, its magnitude and its direction.
    logic [DISP_W-1:0]        diff_ba;
    logic [DISP_W-1:0]        diff_ab;
    logic signed [DISP_W-1:0] d1_reg;
    logic                     pos1_reg;
    logic [COORD_BITS-1:0]    mag1_reg;

    assign diff_ba = {1'b0, second} - {1'b0, first};
    assign diff_ab = {1'b0, first} - {1'b0, second};

    always_ff @(posedge aclk) begin
        if (en) begin
            d1_reg   <= signed'(diff_ba);
            pos1_reg <= diff_ab[COORD_BITS];
            mag1_reg <= diff_ab[COORD_BITS] ? diff_ba[COORD_BITS-1:0]
                                            : diff_ab[COORD_BITS-1:0];
        end
    end

    // Stage 2: half-box test as 2*|d| >= L and the shift by one box length.
    logic                     far;
    logic signed [DISP_W-1:0] len_s;
    logic signed [DISP_W-1:0] d_minus;
    logic signed [DISP_W-1:0] d_plus;
    logic signed [DISP_W-1:0] disp2_reg;
    mipc_pkg::img_t           img2_reg;

    assign far     = {mag1_reg, 1'b0} >= {1'b0, box_len};
    assign len_s   = signed'({1'b0, box_len});
    assign d_minus = d1_reg - len_s;
    assign d_plus  = d1_reg + len_s;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (!far) begin
                disp2_reg <= d1_reg;
                img2_reg  <= mipc_pkg::IMG_ZERO;
            end else if (pos1_reg) begin
                disp2_reg <= d_minus;
                img2_reg  <= mipc_pkg::IMG_NEG;
            end else begin
                disp2_reg <= d_plus;
                img2_reg  <= mipc_pkg::IMG_POS;
            end
        end
    end

    // Stage 3: magnitude of the shifted displacement, which always fits the coordinate width.
    logic signed [DISP_W-1:0] neg2;
    logic [COORD_BITS-1:0]    amag3_reg;
    logic signed [DISP_W-1:0] disp3_reg;
    mipc_pkg::img_t           img3_reg;

    assign neg2 = -disp2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            amag3_reg <= disp2_reg[COORD_BITS] ? neg2[COORD_BITS-1:0]
                                               : disp2_reg[COORD_BITS-1:0];
            disp3_reg <= disp2_reg;
            img3_reg  <= img2_reg;
        end
    end

    // Stage 4: square.
    logic [SQ_W-1:0]          sq4_reg;
    logic signed [DISP_W-1:0] disp4_reg;
    mipc_pkg::img_t           img4_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sq4_reg   <= SQ_W'(amag3_reg) * SQ_W'(amag3_reg);
            disp4_reg <= disp3_reg;
            img4_reg  <= img3_reg;
        end
    end

    assign disp = disp4_reg;
    assign img  = img4_reg;
    assign sq   = sq4_reg;

endmodule

[hw/rtl/mipc_sqrt.sv]
module mipc_sqrt #(
    parameter int ROOT_W = 25,
    parameter int SIDE_W = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [2*ROOT_W-1:0]   in_radicand,
    input  logic [SIDE_W-1:0]     in_side,
    output logic                  out_valid,
    output logic [ROOT_W-1:0]     out_root,
    output logic [SIDE_W-1:0]     out_side
);

    localparam int RAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 3;

    // Stage 0 registers the radicand; stage k settles root bit ROOT_W-k.
    logic              vld_reg  [ROOT_W+1];
    logic [ROOT_W-1:0] root_reg [ROOT_W+1];
    logic [SIDE_W-1:0] side_reg [ROOT_W+1];
    logic [RAD_W-1:0]  rad_reg  [ROOT_W];
    logic [REM_W-1:0]  rem_reg  [ROOT_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg[0]  <= in_radicand;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            side_reg[0] <= in_side;
        end
    end

    for (genvar k = 1; k <= ROOT_W; k++) begin : g_step
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        logic [REM_W-1:0] rem_sub;
        logic             ge;

        assign rem_sh  = {rem_reg[k-1][REM_W-3:0], rad_reg[k-1][RAD_W-1 -: 2]};
        assign trial   = {1'b0, root_reg[k-1], 2'b01};
        assign ge      = rem_sh >= trial;
        assign rem_sub = rem_sh - trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                root_reg[k] <= {root_reg[k-1][ROOT_W-2:0], ge};
                side_reg[k] <= side_reg[k-1];
            end
        end

        if (k < ROOT_W) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k] <= ge ? rem_sub : rem_sh;
                    rad_reg[k] <= {rad_reg[k-1][RAD_W-3:0], 2'b00};
                end
            end
        end
    end

    assign out_valid = vld_reg[ROOT_W];
    assign out_root  = root_reg[ROOT_W];
    assign out_side  = side_reg[ROOT_W];

endmodule

[hw/rtl/min_image_pair_cutoff_test_unit.sv]
// Channel  | Ports                          | Direction | Contents
// ---------+--------------------------------+-----------+---------------------------------
// pair in  | s_tvalid, s_tready, s_tdata    | input     | two atom positions, index, room
// result   | m_tvalid, m_tready, m_tdata    | output    | hit, stored flag and list entry
// config   | cfg_wr_en, cfg_index, cfg_wdata| input     | box lengths and cutoff radius
//
// One pair request is taken in every clock cycle unless the result side stalls. A result
// passes through the minimum-image stages, the two adds and the square-root pipeline;
// most of the pipeline is the square root, which settles one root bit per stage.
// Reset is synchronous and active low; it empties the pipeline and the input buffer and
// loads the default box lengths and cutoff. A stall on the result side freezes the whole
// pipeline; one further request is then held in an input buffer, so s_tready is a register.
module min_image_pair_cutoff_test_unit #(
    parameter int COORD_BITS = 24,
    parameter int FRAC_BITS  = 14,
    parameter int INDEX_BITS = 20,
    localparam int IN_BITS   = 6 * COORD_BITS + INDEX_BITS + 1,
    localparam int IN_W      = (IN_BITS + 7) / 8 * 8,
    localparam int DISP_W    = COORD_BITS + 1,
    localparam int SIDE_W    = 2 + INDEX_BITS + 6 + 3 * DISP_W,
    localparam int OUT_BITS  = SIDE_W + DISP_W,
    localparam int OUT_W     = (OUT_BITS + 7) / 8 * 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // s_tdata, lowest bit first: first_x, first_y, first_z, second_x, second_y,
    // second_z, neighbour_index, has_room, zero padding.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [IN_W-1:0]                     s_tdata,
    // m_tdata, lowest bit first: within_cutoff, stored, neighbour_out, image_x,
    // image_y, image_z, disp_x, disp_y, disp_z, distance, zero padding.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [OUT_W-1:0]                    m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [mipc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [COORD_BITS-1:0]               cfg_wdata
);

    localparam int SQ_W    = 2 * COORD_BITS;
    localparam int SUM_W   = 2 * COORD_BITS + 2;
    localparam int PRE_W   = INDEX_BITS + 6 + 3 * DISP_W;
    localparam int OFF_IDX = 6 * COORD_BITS;

    // Defaults are 10.0 for each box length and 5.0 for the cutoff.
    localparam logic [COORD_BITS-1:0] BOX_RESET = COORD_BITS'(64'd10 << FRAC_BITS);
    localparam logic [COORD_BITS-1:0] CUT_RESET = COORD_BITS'(64'd5 << FRAC_BITS);
    // Minimum squared distance of 0.01, rounded to nearest.
    localparam logic [63:0] MIN_SQ = ((64'd1 << (2 * FRAC_BITS)) + 64'd50) / 64'd100;

    // ------------------------------------------------------------------
    // Config registers: the user must write only while idle; the block does not check.
    // ------------------------------------------------------------------
    logic [COORD_BITS-1:0] box_len_x_reg, box_len_x_next;
    logic [COORD_BITS-1:0] box_len_y_reg, box_len_y_next;
    logic [COORD_BITS-1:0] box_len_z_reg, box_len_z_next;
    logic [COORD_BITS-1:0] cutoff_reg, cutoff_next;

    always_comb begin
        box_len_x_next = box_len_x_reg;
        box_len_y_next = box_len_y_reg;
        box_len_z_next = box_len_z_reg;
        cutoff_next    = cutoff_reg;
        if (cfg_wr_en) begin
            unique case (mipc_pkg::cfg_reg_t'(cfg_index))
                mipc_pkg::CFG_BOX_LEN_X: box_len_x_next = cfg_wdata;
                mipc_pkg::CFG_BOX_LEN_Y: box_len_y_next = cfg_wdata;
                mipc_pkg::CFG_BOX_LEN_Z: box_len_z_next = cfg_wdata;
                mipc_pkg::CFG_CUTOFF:    cutoff_next    = cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_len_x_reg <= BOX_RESET;
            box_len_y_reg <= BOX_RESET;
            box_len_z_reg <= BOX_RESET;
            cutoff_reg    <= CUT_RESET;
        end else begin
            box_len_x_reg <= box_len_x_next;
            box_len_y_reg <= box_len_y_next;
            box_len_z_reg <= box_len_z_next;
            cutoff_reg    <= cutoff_next;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline advance: every stage moves together unless a finished result
    // is waiting on the output.
    // ------------------------------------------------------------------
    logic en;
    logic in_valid;
    logic [IN_BITS-1:0] in_data;

    assign en = !m_tvalid || m_tready;

    mipc_skid #(
        .W (IN_BITS)
    ) u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .s_data    (s_tdata[IN_BITS-1:0]),
        .en        (en),
        .out_valid (in_valid),
        .out_data  (in_data)
    );

    // ------------------------------------------------------------------
    // Stages 1 to 4: one minimum-image unit per axis.
    // ------------------------------------------------------------------
    logic signed [DISP_W-1:0] disp_x, disp_y, disp_z;
    mipc_pkg::img_t           img_x, img_y, img_z;
    logic [SQ_W-1:0]          sq_x, sq_y, sq_z;

    mipc_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
        .aclk    (aclk),
        .en      (en),
        .first   (in_data[0*COORD_BITS +: COORD_BITS]),
        .second  (in_data[3*COORD_BITS +: COORD_BITS]),
        .box_len (box_len_x_reg),
        .disp    (disp_x),
        .img     (img_x),
        .sq      (sq_x)
    );

    mipc_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
        .aclk    (aclk),
        .en      (en),
        .first   (in_data[1*COORD_BITS +: COORD_BITS]),
        .second  (in_data[4*COORD_BITS +: COORD_BITS]),
        .box_len (box_len_y_reg),
        .disp    (disp_y),
        .img     (img_y),
        .sq      (sq_y)
    );

    mipc_axis #(.COORD_BITS(COORD_BITS)) u_axis_z (
        .aclk    (aclk),
        .en      (en),
        .first   (in_data[2*COORD_BITS +: COORD_BITS]),
        .second  (in_data[5*COORD_BITS +: COORD_BITS]),
        .box_len (box_len_z_reg),
        .disp    (disp_z),
        .img     (img_z),
        .sq      (sq_z)
    );

    // Valid bits for stages 1 to 6, and the index and room flag for stages 1 to 4.
    logic                  vld_reg  [6];
    logic [INDEX_BITS-1:0] idx_reg  [4];
    logic                  room_reg [4];
    logic [SQ_W-1:0]       cut4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 6; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < 6; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            idx_reg[0]  <= in_data[OFF_IDX +: INDEX_BITS];
            room_reg[0] <= in_data[OFF_IDX + INDEX_BITS];
            for (int k = 1; k < 4; k++) begin
                idx_reg[k]  <= idx_reg[k-1];
                room_reg[k] <= room_reg[k-1];
            end
            // The squared cutoff is formed alongside the axis squares.
            cut4_reg <= SQ_W'(cutoff_reg) * SQ_W'(cutoff_reg);
        end
    end

    // List entry fields in output order, index lowest.
    logic [PRE_W-1:0] pre4;

    assign pre4 = {disp_z, disp_y, disp_x, img_z, img_y, img_x, idx_reg[3]};

    // ------------------------------------------------------------------
    // Stages 5 and 6: the sum of squares, in two adds.
    // ------------------------------------------------------------------
    logic [SQ_W:0]      sxy5_reg;
    logic [SQ_W-1:0]    sqz5_reg;
    logic [SQ_W-1:0]    cut5_reg;
    logic [PRE_W-1:0]   pre5_reg;
    logic               room5_reg;
    logic [SUM_W-1:0]   sum6_reg;
    logic [SQ_W-1:0]    cut6_reg;
    logic [PRE_W-1:0]   pre6_reg;
    logic               room6_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sxy5_reg  <= {1'b0, sq_x} + {1'b0, sq_y};
            sqz5_reg  <= sq_z;
            cut5_reg  <= cut4_reg;
            pre5_reg  <= pre4;
            room5_reg <= room_reg[3];

            sum6_reg  <= {1'b0, sxy5_reg} + SUM_W'(sqz5_reg);
            cut6_reg  <= cut5_reg;
            pre6_reg  <= pre5_reg;
            room6_reg <= room5_reg;
        end
    end

    // Cutoff and minimum-distance test. A pair that is not stored reports all
    // entry fields as zero, so its radicand is forced to zero as well.
    logic               hit;
    logic               store;
    logic [SUM_W-1:0]   radicand;
    logic [SIDE_W-1:0]  side;

    assign hit      = (sum6_reg <= SUM_W'(cut6_reg)) && (64'(sum6_reg) >= MIN_SQ);
    assign store    = hit && room6_reg;
    assign radicand = store ? sum6_reg : '0;
    assign side     = {(store ? pre6_reg : PRE_W'(0)), store, hit};

    // ------------------------------------------------------------------
    // Stage 7 onwards: pipelined square root, whose last stage is the output register.
    // ------------------------------------------------------------------
    logic [DISP_W-1:0] root;
    logic [SIDE_W-1:0] side_out;

    mipc_sqrt #(
        .ROOT_W (DISP_W),
        .SIDE_W (SIDE_W)
    ) u_sqrt (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (vld_reg[5]),
        .in_radicand (radicand),
        .in_side     (side),
        .out_valid   (m_tvalid),
        .out_root    (root),
        .out_side    (side_out)
    );

    assign m_tdata = OUT_W'({root, side_out});

endmodule

[hw/rtl/mipc_checker.sv]
module mipc_checker #(
    parameter int COORD_BITS = 24,
    parameter int INDEX_BITS = 20,
    localparam int DISP_W    = COORD_BITS + 1,
    localparam int OUT_BITS  = 2 + INDEX_BITS + 6 + 4 * DISP_W,
    localparam int OUT_W     = (OUT_BITS + 7) / 8 * 8
) (
    input logic             aclk,
    input logic             aresetn,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    localparam int OFF_IMG = 2 + INDEX_BITS;

    function automatic logic img_ok(input mipc_pkg::img_t c);
        return (c == mipc_pkg::IMG_NEG) || (c == mipc_pkg::IMG_ZERO)
            || (c == mipc_pkg::IMG_POS);
    endfunction

    // A waiting result stays put until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // A stored entry is always a hit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] || !m_tdata[1]))
        else $error("stored without a hit");

    // An entry that is not stored carries only zeros above the two flags.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[1] |-> (m_tdata[OUT_W-1:2] == '0))
        else $error("entry fields not cleared");

    // Image offsets are -1, 0 or +1 on every axis.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> img_ok(m_tdata[OFF_IMG +: 2]) && img_ok(m_tdata[OFF_IMG + 2 +: 2])
                     && img_ok(m_tdata[OFF_IMG + 4 +: 2]))
        else $error("image offset out of range");

endmodule

bind min_image_pair_cutoff_test_unit mipc_checker #(
    .COORD_BITS (COORD_BITS),
    .INDEX_BITS (INDEX_BITS)
) u_mipc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    // Block configuration used by this bench: the defaults of the unit.
    localparam int COORD_BITS = 24;
    localparam int INDEX_BITS = 20;
    localparam int DISP_W     = COORD_BITS + 1;

    // Time from a request to its result when nothing stalls.
    localparam int RESULT_LATENCY = COORD_BITS + 8;

    // Cycles without any request moving on either channel before the run is abandoned.
    // The longest legal quiet stretch is the deliberate result hold-off below.
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 400;
    localparam int NUM_PHASES     = 10;

    localparam logic [COORD_BITS-1:0] COORD_MAX    = '1;
    localparam logic [INDEX_BITS-1:0] INDEX_MAX    = '1;
    localparam logic [COORD_BITS-1:0] BOX_RESET    = 24'd163840;   // 10.0 angstroms
    localparam logic [COORD_BITS-1:0] CUTOFF_RESET = 24'd81920;    // 5.0 angstroms
    localparam logic [COORD_BITS-1:0] ONE_ANGSTROM = 24'd16384;

    // 0.01 square angstroms with 28 fraction bits, rounded to nearest.
    localparam longint unsigned MIN_DIST_SQ = ((64'd1 << 28) + 64'd50) / 64'd100;

    // Pair request, declared from the highest field down so that first_x lands in the
    // lowest bits of s_tdata.
    typedef struct packed {
        logic                  has_room;
        logic [INDEX_BITS-1:0] neighbour_index;
        logic [COORD_BITS-1:0] second_z;
        logic [COORD_BITS-1:0] second_y;
        logic [COORD_BITS-1:0] second_x;
        logic [COORD_BITS-1:0] first_z;
        logic [COORD_BITS-1:0] first_y;
        logic [COORD_BITS-1:0] first_x;
    } pair_req_t;

    // Result, again highest field first; within_cutoff is bit 0 of m_tdata.
    typedef struct packed {
        logic [DISP_W-1:0]     distance;
        logic [DISP_W-1:0]     disp_z;
        logic [DISP_W-1:0]     disp_y;
        logic [DISP_W-1:0]     disp_x;
        mipc_pkg::img_t        image_z;
        mipc_pkg::img_t        image_y;
        mipc_pkg::img_t        image_x;
        logic [INDEX_BITS-1:0] neighbour_out;
        logic                  stored;
        logic                  within_cutoff;
    } pair_result_t;

    localparam int IN_W  = ($bits(pair_req_t) + 7) / 8 * 8;
    localparam int OUT_W = ($bits(pair_result_t) + 7) / 8 * 8;

    // One row of the directed table. Where the outcome is obvious it is typed in
    // (typed = 1); otherwise the predictor supplies it.
    typedef struct {
        pair_req_t    req;
        logic         typed;
        pair_result_t res;
    } directed_row_t;

    logic                                aclk      = 1'b0;
    logic                                aresetn   = 1'b0;
    logic                                s_tvalid  = 1'b0;
    logic                                s_tready;
    logic [IN_W-1:0]                     s_tdata   = '0;
    logic                                m_tvalid;
    logic                                m_tready  = 1'b0;
    logic [OUT_W-1:0]                    m_tdata;
    logic                                cfg_wr_en = 1'b0;
    logic [mipc_pkg::CFG_INDEX_BITS-1:0] cfg_index = mipc_pkg::CFG_BOX_LEN_X;
    logic [COORD_BITS-1:0]               cfg_wdata = '0;

    // The bench's own copy of the configuration registers, axis order x, y, z.
    logic [COORD_BITS-1:0] box_len [3] = '{BOX_RESET, BOX_RESET, BOX_RESET};
    logic [COORD_BITS-1:0] cutoff_len = CUTOFF_RESET;

    // Results still owed by the block, oldest first.
    pair_result_t pending_results [$];

    int unsigned mismatch_count = 0;
    int unsigned tx_idle_pct    = 0;
    int unsigned rx_stall_pct   = 0;
    logic        rx_hold        = 1'b0;
    int unsigned quiet_cycles   = 0;

    always #5 aclk = ~aclk;

    min_image_pair_cutoff_test_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Floor square root, settled one result bit at a time from the top. The squared
    // distance stays below 2^50, so the root fits in 25 bits.
    function automatic logic [DISP_W-1:0] floor_root(longint unsigned n);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = DISP_W - 1; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= n) begin
                root = trial;
            end
        end
        return root[DISP_W-1:0];
    endfunction

    // Minimum-image fold of one axis. A difference whose doubled magnitude reaches the
    // box length is moved one box length towards zero, and the image offset records the
    // direction. Returns the squared folded difference.
    function automatic longint unsigned fold_axis(input logic [COORD_BITS-1:0] a,
                                                  input logic [COORD_BITS-1:0] b,
                                                  input logic [COORD_BITS-1:0] len,
                                                  output logic [DISP_W-1:0] disp,
                                                  output mipc_pkg::img_t img);
        longint diff;
        longint mag;
        diff = longint'(b) - longint'(a);
        mag  = (diff < 0) ? -diff : diff;
        img  = mipc_pkg::IMG_ZERO;
        if (2 * mag >= longint'(len)) begin
            if (b > a) begin
                img  = mipc_pkg::IMG_NEG;
                diff = diff - longint'(len);
            end else begin
                img  = mipc_pkg::IMG_POS;
                diff = diff + longint'(len);
            end
        end
        disp = diff[DISP_W-1:0];
        mag  = (diff < 0) ? -diff : diff;
        return longint'(mag * mag);
    endfunction

    // Expected result of one pair under the current register settings.
    function automatic pair_result_t predict_pair_result(pair_req_t r);
        pair_result_t      res;
        logic [DISP_W-1:0] dx, dy, dz;
        mipc_pkg::img_t    ix, iy, iz;
        longint unsigned   dist_sq;
        longint unsigned   cut_sq;
        logic              hit;
        dist_sq = fold_axis(r.first_x, r.second_x, box_len[0], dx, ix);
        dist_sq += fold_axis(r.first_y, r.second_y, box_len[1], dy, iy);
        dist_sq += fold_axis(r.first_z, r.second_z, box_len[2], dz, iz);
        cut_sq  = 64'(cutoff_len) * 64'(cutoff_len);
        hit     = (dist_sq <= cut_sq) && (dist_sq >= MIN_DIST_SQ);
        res     = '0;
        res.within_cutoff = hit;
        // Everything but the two flags reads as zero unless the entry is stored.
        if (hit && r.has_room) begin
            res.stored        = 1'b1;
            res.neighbour_out = r.neighbour_index;
            res.image_x       = ix;
            res.image_y       = iy;
            res.image_z       = iz;
            res.disp_x        = dx;
            res.disp_y        = dy;
            res.disp_z        = dz;
            res.distance      = floor_root(dist_sq);
        end
        return res;
    endfunction

    function automatic pair_req_t mk_pair(logic [COORD_BITS-1:0] fx, logic [COORD_BITS-1:0] fy,
                                          logic [COORD_BITS-1:0] fz, logic [COORD_BITS-1:0] sx,
                                          logic [COORD_BITS-1:0] sy, logic [COORD_BITS-1:0] sz,
                                          logic [INDEX_BITS-1:0] idx, logic room);
        pair_req_t r;
        r.first_x         = fx;
        r.first_y         = fy;
        r.first_z         = fz;
        r.second_x        = sx;
        r.second_y        = sy;
        r.second_z        = sz;
        r.neighbour_index = idx;
        r.has_room        = room;
        return r;
    endfunction

    function automatic pair_result_t mk_result(logic hit, logic stored,
                                               logic [INDEX_BITS-1:0] idx,
                                               logic [DISP_W-1:0] dx,
                                               logic [DISP_W-1:0] root_len);
        pair_result_t res;
        res               = '0;
        res.within_cutoff = hit;
        res.stored        = stored;
        res.neighbour_out = idx;
        res.disp_x        = dx;
        res.distance      = root_len;
        return res;
    endfunction

    // Random pair. Most pairs are neighbours: a point inside the box and a second one a
    // random offset away, reaching a little past the cutoff and wrapped back into the
    // box, so that hits, misses and image shifts all occur. A share of pairs sit close
    // to the minimum distance, and the rest are raw noise over the whole field range.
    function automatic pair_req_t random_pair();
        pair_req_t             r;
        logic [COORD_BITS-1:0] a [3];
        logic [COORD_BITS-1:0] b [3];
        longint                len;
        longint                span;
        longint                off;
        longint                pos;
        int unsigned           kind;
        kind = $urandom_range(99, 0);
        span = (kind < 20) ? 64'sd2000 : longint'(cutoff_len) + longint'(cutoff_len) / 4 + 1;
        for (int k = 0; k < 3; k++) begin
            len  = longint'(box_len[k]);
            a[k] = (len == 0) ? COORD_BITS'($urandom)
                              : COORD_BITS'($urandom_range(32'(len - 1), 0));
            off  = longint'($urandom_range(32'(2 * span), 0)) - span;
            pos  = longint'(a[k]) + off;
            if (len == 0) begin
                pos = (pos < 0) ? 0 : ((pos > longint'(COORD_MAX)) ? longint'(COORD_MAX) : pos);
            end else begin
                pos = ((pos % len) + len) % len;
            end
            b[k] = pos[COORD_BITS-1:0];
            if (kind >= 85) begin
                a[k] = COORD_BITS'($urandom);
                b[k] = COORD_BITS'($urandom);
            end
        end
        return mk_pair(a[0], a[1], a[2], b[0], b[1], b[2], INDEX_BITS'($urandom),
                       logic'($urandom_range(3, 0) != 0));
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] seen);
        if (seen !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
            mismatch_count++;
        end
    endfunction

    function automatic void check_result(pair_result_t got);
        pair_result_t want;
        if (pending_results.size() == 0) begin
            $error("result arrived with no request outstanding: 0x%0h", got);
            mismatch_count++;
            return;
        end
        want = pending_results.pop_front();
        check_field("within_cutoff", 32'(want.within_cutoff), 32'(got.within_cutoff));
        check_field("stored",        32'(want.stored),        32'(got.stored));
        check_field("neighbour_out", 32'(want.neighbour_out), 32'(got.neighbour_out));
        check_field("image_x",       32'(want.image_x),       32'(got.image_x));
        check_field("image_y",       32'(want.image_y),       32'(got.image_y));
        check_field("image_z",       32'(want.image_z),       32'(got.image_z));
        check_field("disp_x",        32'(want.disp_x),        32'(got.disp_x));
        check_field("disp_y",        32'(want.disp_y),        32'(got.disp_y));
        check_field("disp_z",        32'(want.disp_z),        32'(got.disp_z));
        check_field("distance",      32'(want.distance),      32'(got.distance));
    endfunction

    // Offers one pair request, after a random number of idle cycles, and waits until the
    // block takes it. The expectation is queued at the edge of acceptance, so it is
    // always computed under the register values the block itself uses. The task is
    // entered and left just after a rising edge; s_tvalid is left high for the caller.
    task automatic send_pair(pair_req_t r, logic typed, pair_result_t typed_res);
        while ($urandom_range(99, 0) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_W'(r);
        do begin
            @(posedge aclk);
        end while (!s_tready);
        pending_results.push_back(typed ? typed_res : predict_pair_result(r));
    endtask

    // One register write, taking effect at the next rising edge. The caller lowers the
    // write enable after the last write of a group.
    task automatic write_reg(mipc_pkg::cfg_reg_t idx, logic [COORD_BITS-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            mipc_pkg::CFG_BOX_LEN_X: box_len[0] = val;
            mipc_pkg::CFG_BOX_LEN_Y: box_len[1] = val;
            mipc_pkg::CFG_BOX_LEN_Z: box_len[2] = val;
            mipc_pkg::CFG_CUTOFF:    cutoff_len = val;
            default: ;
        endcase
    endtask

    // Result side: checks every accepted result against the oldest expectation and
    // then decides whether to accept in the next cycle. The long hold-off wins over
    // the random stall.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_result(pair_result_t'(m_tdata));
            end
            if (rx_hold) begin
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99, 0) >= rx_stall_pct);
            end
        end
    end

    // Watchdog: counts cycles in which no request moves on either channel.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $error("no request moved for %0d cycles, %0d results outstanding",
                   quiet_cycles, pending_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        directed_row_t         rows [$];
        logic [COORD_BITS-1:0] lens [3];
        logic [COORD_BITS-1:0] cut;
        logic [COORD_BITS-1:0] shortest;
        int unsigned           mode;
        int unsigned           count;

        // Directed table, run under the reset geometry: a 10 angstrom cube and a
        // 5 angstrom cutoff.
        // Coincident atoms fall below the minimum distance, with and without room.
        rows.push_back(directed_row_t'{mk_pair(0, 0, 0, 0, 0, 0, 0, 1'b0), 1'b1, '0});
        rows.push_back(directed_row_t'{mk_pair(0, 0, 0, 0, 0, 0, INDEX_MAX, 1'b1), 1'b1, '0});
        // Coordinate extremes: far apart even after the fold, so a miss on every axis.
        rows.push_back(directed_row_t'{mk_pair(0, 0, 0, COORD_MAX, COORD_MAX, COORD_MAX,
                                               INDEX_MAX, 1'b1), 1'b1, '0});
        rows.push_back(directed_row_t'{mk_pair(COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, 0,
                                               0, 1'b1), 1'b1, '0});
        // One angstrom apart along x: a plain hit, stored; then the same hit with the
        // list full, where only the hit flag is set.
        rows.push_back(directed_row_t'{mk_pair(0, 0, 0, ONE_ANGSTROM, 0, 0, 5, 1'b1), 1'b1,
                                       mk_result(1'b1, 1'b1, 5, ONE_ANGSTROM, ONE_ANGSTROM)});
        rows.push_back(directed_row_t'{mk_pair(0, 0, 0, ONE_ANGSTROM, 0, 0, 6, 1'b0), 1'b1,
                                       mk_result(1'b1, 1'b0, 0, 0, 0)});
        // Pairs that wrap across the box on each axis; z is wrapped in both directions.
        rows.push_back(directed_row_t'{mk_pair(0, 0, 0, 147456, 0, 0, 7, 1'b1), 1'b0, '0});
        rows.push_back(directed_row_t'{mk_pair(0, 147456, 0, 0, 0, 0, 8, 1'b1), 1'b0, '0});
        rows.push_back(directed_row_t'{mk_pair(0, 0, 147456, 0, 0, 0, 9, 1'b1), 1'b0, '0});
        rows.push_back(directed_row_t'{mk_pair(0, 0, 0, 0, 0, 147456, 10, 1'b1), 1'b0, '0});
        // Exactly half a box: folded, and then exactly on the cutoff.
        rows.push_back(directed_row_t'{mk_pair(0, 0, 0, 81920, 0, 0, 11, 1'b1), 1'b0, '0});
        // Just short of half a box: not folded.
        rows.push_back(directed_row_t'{mk_pair(0, 0, 0, 81919, 0, 0, 12, 1'b1), 1'b0, '0});
        // One step beyond the cutoff.
        rows.push_back(directed_row_t'{mk_pair(0, 0, 0, 81920, 1, 0, 13, 1'b1), 1'b0, '0});
        // Either side of the minimum distance.
        rows.push_back(directed_row_t'{mk_pair(0, 0, 0, 1638, 0, 0, 14, 1'b1), 1'b0, '0});
        rows.push_back(directed_row_t'{mk_pair(0, 0, 0, 1639, 0, 0, 15, 1'b1), 1'b0, '0});
        rows.push_back(directed_row_t'{mk_pair(81920, 81920, 81920, 81920, 81920, 81920,
                                               16, 1'b1), 1'b0, '0});
        // Coordinates outside the box are taken as they are.
        rows.push_back(directed_row_t'{mk_pair(COORD_MAX - 1000, 200000, 0, COORD_MAX,
                                               216384, 5000, 17, 1'b1), 1'b0, '0});
        rows.push_back(directed_row_t'{mk_pair(COORD_MAX, 0, 0, COORD_MAX - 100000, 0, 0,
                                               18, 1'b1), 1'b0, '0});
        // All three axes folded, in each direction, and then a short diagonal with no fold.
        rows.push_back(directed_row_t'{mk_pair(1000, 1000, 1000, 160000, 160000, 160000,
                                               19, 1'b1), 1'b0, '0});
        rows.push_back(directed_row_t'{mk_pair(160000, 160000, 160000, 1000, 1000, 1000,
                                               20, 1'b1), 1'b0, '0});
        rows.push_back(directed_row_t'{mk_pair(5000, 5000, 5000, 13000, 13000, 13000,
                                               INDEX_MAX, 1'b1), 1'b0, '0});

        // Synchronous reset, applied once at the start and never repeated.
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) begin
            send_pair(rows[i].req, rows[i].typed, rows[i].res);
        end
        s_tvalid <= 1'b0;

        // Random phases. Each one waits for the block to empty, loads a new geometry
        // and idling pattern, and streams pairs. The idling pattern cycles through
        // none, sender idle, receiver stalling and both lightly; phase 5 uses none.
        for (int p = 0; p < NUM_PHASES; p++) begin
            while (pending_results.size() != 0) begin
                @(posedge aclk);
            end

            lens  = '{BOX_RESET, BOX_RESET, BOX_RESET};
            cut   = CUTOFF_RESET;
            count = 80;
            mode  = p % 4;
            case (p)
                0: count = 150;
                1: begin
                    lens  = '{24'd1638400, 24'd1638400, 24'd1638400};
                    cut   = 24'd409600;
                    count = 120;
                end
                2: begin
                    // Largest box and cutoff: every pair clear of the minimum is a hit.
                    lens  = '{COORD_MAX, COORD_MAX, COORD_MAX};
                    cut   = COORD_MAX;
                    count = 120;
                end
                3: begin
                    // Degenerate boxes, one of them of zero length, along which every
                    // pair records an image without moving.
                    lens = '{24'd1, 24'd0, 24'd2};
                    cut  = 24'd163840;
                end
                4: begin
                    // Zero cutoff: nothing can be a hit.
                    cut   = '0;
                    count = 60;
                end
                default: begin
                    for (int k = 0; k < 3; k++) begin
                        lens[k] = ($urandom_range(1, 0) != 0)
                                  ? COORD_BITS'($urandom_range(32'(COORD_MAX), 1))
                                  : COORD_BITS'($urandom_range(400000, 20000));
                    end
                    shortest = lens[0];
                    if (lens[1] < shortest) shortest = lens[1];
                    if (lens[2] < shortest) shortest = lens[2];
                    cut = COORD_BITS'($urandom_range(32'(shortest / 2), 0));
                    if (p == 5) begin
                        count = 120;
                        mode  = 0;
                    end
                end
            endcase

            write_reg(mipc_pkg::CFG_BOX_LEN_X, lens[0]);
            write_reg(mipc_pkg::CFG_BOX_LEN_Y, lens[1]);
            write_reg(mipc_pkg::CFG_BOX_LEN_Z, lens[2]);
            write_reg(mipc_pkg::CFG_CUTOFF, cut);
            cfg_wr_en <= 1'b0;

            tx_idle_pct  =  (mode == 1) ? 85 : ((mode == 3) ? 9 : 0);
            rx_stall_pct <= (mode == 2) ? 85 : ((mode == 3) ? 9 : 0);

            if (p == 5) begin
                // The result side holds off for a long stretch while requests keep
                // coming, so that the pipeline and the input buffer fill and the block
                // has to push back on its input.
                fork
                    begin
                        rx_hold <= 1'b1;
                        repeat (HOLD_CYCLES) @(posedge aclk);
                        rx_hold <= 1'b0;
                    end
                    for (int n = 0; n < count; n++) begin
                        send_pair(random_pair(), 1'b0, '0);
                    end
                join
            end else begin
                for (int n = 0; n < count; n++) begin
                    send_pair(random_pair(), 1'b0, '0);
                end
            end
            s_tvalid <= 1'b0;
        end

        // Let every owed result arrive, then watch a while longer for strays.
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (2 * RESULT_LATENCY) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
